// ----- sv/esc_pkg.sv -----
// Shared types and constants of the environmental sensor compensation block.
package esc_pkg;

   typedef struct packed {
      logic [19:0] adc_temperature;
      logic [19:0] adc_pressure;
      logic [15:0] adc_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic [16:0]        humidity_q22_10;
      logic               pressure_invalid;
   } rsp_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_TRIM    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TRIM_A = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TRIM_B = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TRIM_C = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HUM_TRIM     = 3'd4;

   // Pipeline shape: front stages, one divider stage per quotient bit, tail stages.
   localparam int unsigned FRONT_STAGES = 13;
   localparam int unsigned DIV_BITS     = 64;
   localparam int unsigned TAIL_STAGES  = 5;
   localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_BITS + TAIL_STAGES;

   localparam logic signed [33:0] T_FINE_PRESS_OFS = 34'sd128000;
   localparam logic signed [31:0] T_FINE_HUM_OFS   = 32'sd76800;
   localparam logic signed [63:0] PRESS_BASE       = 64'sd1048576;
   localparam logic signed [63:0] PRESS_SCALE      = 64'sd3125;
   localparam logic signed [63:0] PRESS_ONE_Q47    = 64'sh0000_8000_0000_0000;
   localparam logic signed [31:0] HUM_ROUND_A      = 32'sd16384;
   localparam logic signed [31:0] HUM_OFS_B        = 32'sd32768;
   localparam logic signed [31:0] HUM_OFS_C        = 32'sd2097152;
   localparam logic signed [31:0] HUM_ROUND_C      = 32'sd8192;
   localparam logic signed [31:0] HUM_MAX          = 32'sd419430400;

   // Item state entering the divider and flowing through it.
   typedef struct packed {
      logic [30:0]        rem;
      logic [63:0]        work;
      logic [30:0]        md;
      logic               negq;
      logic               inv;
      logic signed [31:0] temp;
      logic [16:0]        hum;
   } div_type;

   // Divider operands waiting for the humidity result.
   typedef struct packed {
      logic [63:0]        ma;
      logic [30:0]        md;
      logic               negq;
      logic               inv;
      logic signed [31:0] temp;
   } dsetup_type;

   // Finished fields riding along the pressure tail.
   typedef struct packed {
      logic               inv;
      logic signed [31:0] temp;
      logic [16:0]        hum;
   } tail_type;

endpackage

// ----- sv/esc_stream_if.sv -----
// Valid/ready stream interface used by the request and response channels.
interface esc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/env_sensor_compensation.sv -----
// The pipe has 13 front stages, 64 divider stages with one quotient bit each and
// 5 tail stages between request transfer and response valid.
// Throughput: one transfer per cycle; the signed 64-bit pressure divide is the
// deepest unit and sets the latency, while a response stall holds every stage.
// Reset clears all stage valid bits and sets every trim register to zero.
module env_sensor_compensation
   import esc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   esc_stream_if.sink             req,
   esc_stream_if.source           rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------------------------------------------------------------------
   // Trim registers. The user must change them only while the pipeline is empty
   // (the block does not enforce it); every stage reads them directly, uncopied.
   // ---------------------------------------------------------------------------
   logic [47:0] temp_trim_ff, press_trim_a_ff, press_trim_b_ff, press_trim_c_ff;
   logic [63:0] hum_trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff    <= '0;
         press_trim_a_ff <= '0;
         press_trim_b_ff <= '0;
         press_trim_c_ff <= '0;
         hum_trim_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_TRIM:    temp_trim_ff    <= csr_wdata[47:0];
            CSR_PRESS_TRIM_A: press_trim_a_ff <= csr_wdata[47:0];
            CSR_PRESS_TRIM_B: press_trim_b_ff <= csr_wdata[47:0];
            CSR_PRESS_TRIM_C: press_trim_c_ff <= csr_wdata[47:0];
            CSR_HUM_TRIM:     hum_trim_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]         h1, h3;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   assign t1 = temp_trim_ff[15:0];
   assign t2 = $signed(temp_trim_ff[31:16]);
   assign t3 = $signed(temp_trim_ff[47:32]);
   assign p1 = press_trim_a_ff[15:0];
   assign p2 = $signed(press_trim_a_ff[31:16]);
   assign p3 = $signed(press_trim_a_ff[47:32]);
   assign p4 = $signed(press_trim_b_ff[15:0]);
   assign p5 = $signed(press_trim_b_ff[31:16]);
   assign p6 = $signed(press_trim_b_ff[47:32]);
   assign p7 = $signed(press_trim_c_ff[15:0]);
   assign p8 = $signed(press_trim_c_ff[31:16]);
   assign p9 = $signed(press_trim_c_ff[47:32]);
   assign h1 = hum_trim_ff[7:0];
   assign h2 = $signed(hum_trim_ff[23:8]);
   assign h3 = hum_trim_ff[31:24];
   assign h4 = $signed(hum_trim_ff[43:32]);
   assign h5 = $signed(hum_trim_ff[55:44]);
   assign h6 = $signed(hum_trim_ff[63:56]);

   // ---------------------------------------------------------------------------
   // Flow control. All stages advance together; a held response freezes the
   // whole pipe, and empty slots still move forward whenever the output drains.
   // ---------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic                  adv;

   assign adv       = ~vld_ff[NUM_STAGES-1] | rsp.ready;
   assign req.ready = adv;
   assign vld_in    = {vld_ff[NUM_STAGES-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stages 1 to 3: fine temperature.
   // ---------------------------------------------------------------------------
   logic [31:0]        td1, td;
   logic signed [31:0] m1_ff, m1_in, dd_ff, dd_in;
   logic [19:0]        adcp1_ff, adcp2_ff, adcp3_ff, adcp4_ff, adcp5_ff, adcp6_ff, adcp7_ff;
   logic [15:0]        adch1_ff, adch2_ff, adch3_ff, adch4_ff, adch5_ff;

   assign td    = {16'b0, req.data.adc_temperature[19:4]} - {16'b0, t1};
   assign td1   = {15'b0, req.data.adc_temperature[19:3]} - {15'b0, t1, 1'b0};
   assign m1_in = 32'($signed(td1) * t2);
   assign dd_in = 32'($signed(td) * $signed(td));

   logic signed [31:0] v1_ff, v1_in, q2_ff, q2_in, tfine_ff, tfine_in;
   assign v1_in    = m1_ff >>> 11;
   assign q2_in    = 32'((dd_ff >>> 12) * t3);
   assign tfine_in = v1_ff + (q2_ff >>> 14);

   // ---------------------------------------------------------------------------
   // Stage 4: temperature result and the offsets used by pressure and humidity.
   // ---------------------------------------------------------------------------
   logic signed [31:0] temp4_ff, temp4_in, hx4_ff, hx4_in;
   logic signed [33:0] a4_ff, a4_in;
   assign temp4_in = (tfine_ff * 32'sd5 + 32'sd128) >>> 8;
   assign a4_in    = 34'(tfine_ff) - T_FINE_PRESS_OFS;
   assign hx4_in   = tfine_ff - T_FINE_HUM_OFS;

   // ---------------------------------------------------------------------------
   // Stages 5 to 9: pressure divisor and dividend, humidity front terms.
   // ---------------------------------------------------------------------------
   logic signed [63:0] aa5_ff, aa5_in, ap5_5_ff, ap5_5_in, ap2_5_ff, ap2_5_in;
   logic signed [31:0] h5x5_ff, h5x5_in, xh6_5_ff, xh6_5_in, xh3_5_ff, xh3_5_in, temp5_ff;
   assign aa5_in   = 64'(a4_ff * a4_ff);
   assign ap5_5_in = 64'(a4_ff * p5);
   assign ap2_5_in = 64'(a4_ff * p2);
   assign h5x5_in  = 32'(hx4_ff * h5);
   assign xh6_5_in = 32'(hx4_ff * h6);
   assign xh3_5_in = 32'(hx4_ff * $signed({1'b0, h3}));

   logic signed [63:0] b0_6_ff, b0_6_in, a3_6_ff, a3_6_in, ap5_6_ff, ap2_6_ff;
   logic signed [31:0] ha6_ff, ha6_in, u6_ff, u6_in, w6_ff, w6_in, temp6_ff;
   assign b0_6_in = 64'(aa5_ff * p6);
   assign a3_6_in = 64'(aa5_ff * p3);
   assign ha6_in  = ($signed({2'b0, adch5_ff, 14'b0}) - $signed({h4, 20'b0}) - h5x5_ff
                     + HUM_ROUND_A) >>> 15;
   assign u6_in   = xh6_5_ff >>> 10;
   assign w6_in   = (xh3_5_ff >>> 11) + HUM_OFS_B;

   logic signed [63:0] b7_ff, b7_in, s7_ff, s7_in;
   logic signed [31:0] uw7_ff, uw7_in, ha7_ff, temp7_ff;
   assign b7_in  = b0_6_ff + (ap5_6_ff <<< 17) + (64'(p4) <<< 35);
   assign s7_in  = PRESS_ONE_Q47 + (a3_6_ff >>> 8) + (ap2_6_ff <<< 12);
   assign uw7_in = 32'(u6_ff * w6_ff);

   logic signed [63:0] m8_ff, m8_in, nb8_ff, nb8_in;
   logic signed [31:0] hb1_8_ff, hb1_8_in, ha8_ff, temp8_ff;
   assign m8_in    = 64'(s7_ff * $signed({1'b0, p1}));
   assign nb8_in   = ((PRESS_BASE - $signed({44'b0, adcp7_ff})) <<< 31) - b7_ff;
   assign hb1_8_in = 32'(((uw7_ff >>> 10) + HUM_OFS_C) * h2);

   logic signed [30:0] den9_ff, den9_in;
   logic signed [63:0] num9_ff, num9_in;
   logic signed [31:0] hb2_9_ff, hb2_9_in, ha9_ff, temp9_ff;
   assign den9_in  = m8_ff[63:33];
   assign num9_in  = 64'(nb8_ff * PRESS_SCALE);
   assign hb2_9_in = (hb1_8_ff + HUM_ROUND_C) >>> 14;

   // ---------------------------------------------------------------------------
   // Stages 10 to 13: divider operand magnitudes, humidity product and clamp.
   // ---------------------------------------------------------------------------
   dsetup_type         dq10_ff, dq10_in, dq11_ff, dq12_ff;
   logic signed [31:0] hxp10_ff, hxp10_in, hxp11_ff, hxp12_ff;
   always_comb begin
      dq10_in.ma   = num9_ff[63] ? 64'(-num9_ff) : num9_ff;
      dq10_in.md   = den9_ff[30] ? 31'(-den9_ff) : den9_ff;
      dq10_in.negq = num9_ff[63] ^ den9_ff[30];
      dq10_in.inv  = (den9_ff == '0);
      dq10_in.temp = temp9_ff;
   end
   assign hxp10_in = 32'(ha9_ff * hb2_9_ff);

   logic signed [31:0] sq11_ff, sq11_in, c12_ff, c12_in, hfin;
   assign sq11_in = 32'((hxp10_ff >>> 15) * (hxp10_ff >>> 15));
   assign c12_in  = 32'((sq11_ff >>> 7) * $signed({1'b0, h1}));
   assign hfin    = hxp12_ff - (c12_ff >>> 4);

   // The divider slot zero doubles as the stage 13 register.
   div_type dv_ff [DIV_BITS+1];
   div_type dv0_in;
   logic [16:0] hum13;

   always_comb begin
      // Negative humidity reads as zero; anything above 100 percent is capped.
      priority if (hfin[31]) begin
         hum13 = '0;
      end else if (hfin > HUM_MAX) begin
         hum13 = HUM_MAX[28:12];
      end else begin
         hum13 = hfin[28:12];
      end
      dv0_in.rem  = '0;
      dv0_in.work = dq12_ff.ma;
      dv0_in.md   = dq12_ff.md;
      dv0_in.negq = dq12_ff.negq;
      dv0_in.inv  = dq12_ff.inv;
      dv0_in.temp = dq12_ff.temp;
      dv0_in.hum  = hum13;
   end

   // ---------------------------------------------------------------------------
   // Restoring divider: one quotient bit per stage. The quotient shifts into the
   // low end of the work word as the dividend bits leave its top.
   // ---------------------------------------------------------------------------
   function automatic div_type div_step(input div_type d);
      logic [31:0] trial;
      logic        ge;
      div_type     o;
      trial  = {d.rem, d.work[63]};
      ge     = (trial >= {1'b0, d.md});
      o      = d;
      o.rem  = ge ? 31'(trial - {1'b0, d.md}) : trial[30:0];
      o.work = {d.work[62:0], ge};
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Tail stages 1 to 5: quotient sign, second-order pressure correction.
   // ---------------------------------------------------------------------------
   tail_type           tl1_ff, tl1_in, tl2_ff, tl3_ff, tl4_ff;
   logic signed [63:0] pq1_ff, pq1_in, pq2_ff, pq3_ff, pq4_ff, ps;
   assign pq1_in      = dv_ff[DIV_BITS].negq ? 64'(-$signed(dv_ff[DIV_BITS].work))
                                             : $signed(dv_ff[DIV_BITS].work);
   assign tl1_in.inv  = dv_ff[DIV_BITS].inv;
   assign tl1_in.temp = dv_ff[DIV_BITS].temp;
   assign tl1_in.hum  = dv_ff[DIV_BITS].hum;

   // Low 64 bits of the square from 32-bit halves.
   logic [63:0]        ll2_ff, ll2_in;
   logic [31:0]        lh2_ff, lh2_in;
   logic signed [63:0] p8p2_ff, p8p2_in, p8p3_ff;
   assign ps      = pq1_ff >>> 13;
   assign ll2_in  = 64'(ps[31:0] * ps[31:0]);
   assign lh2_in  = 32'(ps[31:0] * ps[63:32]);
   assign p8p2_in = 64'(pq1_ff * p8);

   logic signed [63:0] sq3_ff, sq3_in, c1_4_ff, c1_4_in, c2_4_ff, c2_4_in, sum5, res5;
   assign sq3_in  = $signed(ll2_ff + {lh2_ff[30:0], 33'b0});
   assign c1_4_in = 64'(sq3_ff * p9);
   assign c2_4_in = p8p3_ff >>> 19;
   assign sum5    = pq4_ff + (c1_4_ff >>> 25) + c2_4_ff;
   assign res5    = (sum5 >>> 8) + (64'(p7) <<< 4);

   rsp_type out_ff, out_in;
   always_comb begin
      out_in.temperature_centi = tl4_ff.temp;
      out_in.pressure_q24_8    = tl4_ff.inv ? 32'd0 : res5[31:0];
      out_in.humidity_q22_10   = tl4_ff.hum;
      out_in.pressure_invalid  = tl4_ff.inv;
   end

   assign rsp.valid = vld_ff[NUM_STAGES-1];
   assign rsp.data  = out_ff;

   // ---------------------------------------------------------------------------
   // Payload registers, all moving on the common advance.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= m1_in;
         dd_ff    <= dd_in;
         adcp1_ff <= req.data.adc_pressure;
         adch1_ff <= req.data.adc_humidity;

         v1_ff    <= v1_in;
         q2_ff    <= q2_in;
         adcp2_ff <= adcp1_ff;
         adch2_ff <= adch1_ff;

         tfine_ff <= tfine_in;
         adcp3_ff <= adcp2_ff;
         adch3_ff <= adch2_ff;

         temp4_ff <= temp4_in;
         a4_ff    <= a4_in;
         hx4_ff   <= hx4_in;
         adcp4_ff <= adcp3_ff;
         adch4_ff <= adch3_ff;

         aa5_ff   <= aa5_in;
         ap5_5_ff <= ap5_5_in;
         ap2_5_ff <= ap2_5_in;
         h5x5_ff  <= h5x5_in;
         xh6_5_ff <= xh6_5_in;
         xh3_5_ff <= xh3_5_in;
         temp5_ff <= temp4_ff;
         adcp5_ff <= adcp4_ff;
         adch5_ff <= adch4_ff;

         b0_6_ff  <= b0_6_in;
         a3_6_ff  <= a3_6_in;
         ap5_6_ff <= ap5_5_ff;
         ap2_6_ff <= ap2_5_ff;
         ha6_ff   <= ha6_in;
         u6_ff    <= u6_in;
         w6_ff    <= w6_in;
         temp6_ff <= temp5_ff;
         adcp6_ff <= adcp5_ff;

         b7_ff    <= b7_in;
         s7_ff    <= s7_in;
         uw7_ff   <= uw7_in;
         ha7_ff   <= ha6_ff;
         temp7_ff <= temp6_ff;
         adcp7_ff <= adcp6_ff;

         m8_ff    <= m8_in;
         nb8_ff   <= nb8_in;
         hb1_8_ff <= hb1_8_in;
         ha8_ff   <= ha7_ff;
         temp8_ff <= temp7_ff;

         den9_ff  <= den9_in;
         num9_ff  <= num9_in;
         hb2_9_ff <= hb2_9_in;
         ha9_ff   <= ha8_ff;
         temp9_ff <= temp8_ff;

         dq10_ff  <= dq10_in;
         hxp10_ff <= hxp10_in;

         dq11_ff  <= dq10_ff;
         hxp11_ff <= hxp10_ff;
         sq11_ff  <= sq11_in;

         dq12_ff  <= dq11_ff;
         hxp12_ff <= hxp11_ff;
         c12_ff   <= c12_in;

         dv_ff[0] <= dv0_in;
         for (int k = 1; k <= DIV_BITS; k++) begin
            dv_ff[k] <= div_step(dv_ff[k-1]);
         end

         pq1_ff  <= pq1_in;
         tl1_ff  <= tl1_in;

         ll2_ff  <= ll2_in;
         lh2_ff  <= lh2_in;
         p8p2_ff <= p8p2_in;
         pq2_ff  <= pq1_ff;
         tl2_ff  <= tl1_ff;

         sq3_ff  <= sq3_in;
         p8p3_ff <= p8p2_ff;
         pq3_ff  <= pq2_ff;
         tl3_ff  <= tl2_ff;

         c1_4_ff <= c1_4_in;
         c2_4_ff <= c2_4_in;
         pq4_ff  <= pq3_ff;
         tl4_ff  <= tl3_ff;

         out_ff  <= out_in;
      end
   end

endmodule
